// ===== rtl/ade_pkg.sv =====
// ----------------------------------------------------------------------------
// ade_pkg
// Shared types and constants for the data-processing execute block.
// ----------------------------------------------------------------------------
package ade_pkg;

  localparam int unsigned XLEN = 32;

  // instruction bit positions
  localparam int unsigned InsImmBit   = 25;
  localparam int unsigned InsSBit     = 20;
  localparam int unsigned InsRegShBit = 4;
  localparam logic [3:0]  PcIndex     = 4'd15;
  localparam logic [XLEN-1:0] PcReadOffset = 32'd4;

  typedef enum logic [3:0] {
    OP_AND = 4'd0,
    OP_EOR = 4'd1,
    OP_SUB = 4'd2,
    OP_RSB = 4'd3,
    OP_ADD = 4'd4,
    OP_ADC = 4'd5,
    OP_SBC = 4'd6,
    OP_RSC = 4'd7,
    OP_TST = 4'd8,
    OP_TEQ = 4'd9,
    OP_CMP = 4'd10,
    OP_CMN = 4'd11,
    OP_ORR = 4'd12,
    OP_MOV = 4'd13,
    OP_BIC = 4'd14,
    OP_MVN = 4'd15
  } alu_op_e;

  typedef enum logic [1:0] {
    SH_LSL = 2'd0,
    SH_LSR = 2'd1,
    SH_ASR = 2'd2,
    SH_ROR = 2'd3
  } shift_type_e;

  // operand 2 as produced by the barrel shifter
  typedef struct packed {
    logic [XLEN-1:0] value;
    logic            carry;
  } shift_out_t;

  // flag bundle, NZCV order
  typedef struct packed {
    logic n;
    logic z;
    logic c;
    logic v;
  } flags_t;

endpackage

// ===== rtl/ade_shifter.sv =====
// ----------------------------------------------------------------------------
// ade_shifter
// Barrel shifter for operand 2: rotated immediate or shifted Rm, with carry.
// ----------------------------------------------------------------------------
module ade_shifter (
  input  logic [31:0]        instruction_i,
  input  logic [31:0]        rm_i,
  input  logic [31:0]        rs_i,
  input  logic               carry_i,
  output ade_pkg::shift_out_t op2_o
);

  logic [4:0]  rot_amt;
  logic [31:0] imm_rot;
  logic [1:0]  sh_type;
  logic [4:0]  imm_amt;
  logic [7:0]  amt;
  logic [5:0]  asr_amt;
  logic [32:0] lsl_full;
  logic [32:0] lsr_full;
  logic [32:0] asr_full;
  logic [63:0] ror_full;

  assign rot_amt = {instruction_i[11:8], 1'b0};
  assign imm_rot = 32'({instruction_i[7:0], 24'd0, instruction_i[7:0]} >> rot_amt) |
                   32'({24'd0, instruction_i[7:0]} >> rot_amt);
  assign sh_type = instruction_i[6:5];
  assign imm_amt = instruction_i[11:7];

  // immediate lsr/asr by zero encodes a shift by 32
  always_comb begin
    if (instruction_i[ade_pkg::InsRegShBit]) begin
      amt = rs_i[7:0];
    end else if ((imm_amt == 5'd0) &&
                 ((sh_type == ade_pkg::SH_LSR) || (sh_type == ade_pkg::SH_ASR))) begin
      amt = 8'd32;
    end else begin
      amt = {3'd0, imm_amt};
    end
  end

  assign asr_amt  = (amt >= 8'd32) ? 6'd32 : amt[5:0];
  assign lsl_full = {1'b0, rm_i} << amt;
  assign lsr_full = {rm_i, 1'b0} >> amt;
  assign asr_full = 33'($signed({rm_i, 1'b0}) >>> asr_amt);
  assign ror_full = {rm_i, rm_i} >> amt[4:0];

  always_comb begin
    if (instruction_i[ade_pkg::InsImmBit]) begin
      op2_o.value = imm_rot;
      op2_o.carry = (rot_amt == 5'd0) ? carry_i : imm_rot[31];
    end else if (!instruction_i[ade_pkg::InsRegShBit] && (imm_amt == 5'd0) &&
                 (sh_type == ade_pkg::SH_ROR)) begin
      // rrx
      op2_o.value = {carry_i, rm_i[31:1]};
      op2_o.carry = rm_i[0];
    end else if (amt == 8'd0) begin
      op2_o.value = rm_i;
      op2_o.carry = carry_i;
    end else begin
      case (sh_type)
        ade_pkg::SH_LSL: begin
          op2_o.value = lsl_full[31:0];
          op2_o.carry = lsl_full[32];
        end
        ade_pkg::SH_LSR: begin
          op2_o.value = lsr_full[32:1];
          op2_o.carry = lsr_full[0];
        end
        ade_pkg::SH_ASR: begin
          op2_o.value = asr_full[32:1];
          op2_o.carry = asr_full[0];
        end
        default: begin
          op2_o.value = ror_full[31:0];
          op2_o.carry = ror_full[31];
        end
      endcase
    end
  end

endmodule

// ===== rtl/ade_alu.sv =====
// ----------------------------------------------------------------------------
// ade_alu
// Sixteen data-processing operations, flag update and status restore request.
// ----------------------------------------------------------------------------
module ade_alu (
  input  logic [3:0]          opcode_i,
  input  logic                set_flags_i,
  input  logic [3:0]          rd_i,
  input  logic [31:0]         rn_i,
  input  ade_pkg::shift_out_t op2_i,
  input  ade_pkg::flags_t     flags_i,
  output logic [31:0]         result_o,
  output logic                write_enable_o,
  output ade_pkg::flags_t     flags_o,
  output logic                restore_o
);

  logic [31:0] add_a;
  logic [31:0] add_b;
  logic        add_cin;
  logic [32:0] sum;
  logic        add_v;
  logic        logical;
  logic        c_new;
  logic        v_new;

  always_comb begin
    add_a   = rn_i;
    add_b   = op2_i.value;
    add_cin = 1'b0;
    logical = 1'b0;
    case (ade_pkg::alu_op_e'(opcode_i))
      ade_pkg::OP_SUB, ade_pkg::OP_CMP: begin
        add_b   = ~op2_i.value;
        add_cin = 1'b1;
      end
      ade_pkg::OP_RSB: begin
        add_a   = op2_i.value;
        add_b   = ~rn_i;
        add_cin = 1'b1;
      end
      ade_pkg::OP_ADD, ade_pkg::OP_CMN: begin
        add_cin = 1'b0;
      end
      ade_pkg::OP_ADC: begin
        add_cin = flags_i.c;
      end
      ade_pkg::OP_SBC: begin
        add_b   = ~op2_i.value;
        add_cin = flags_i.c;
      end
      ade_pkg::OP_RSC: begin
        add_a   = op2_i.value;
        add_b   = ~rn_i;
        add_cin = flags_i.c;
      end
      default: begin
        logical = 1'b1;
      end
    endcase
  end

  assign sum   = {1'b0, add_a} + {1'b0, add_b} + {32'd0, add_cin};
  assign add_v = (add_a[31] ^ sum[31]) & (add_b[31] ^ sum[31]);

  always_comb begin
    case (ade_pkg::alu_op_e'(opcode_i))
      ade_pkg::OP_AND, ade_pkg::OP_TST: result_o = rn_i & op2_i.value;
      ade_pkg::OP_EOR, ade_pkg::OP_TEQ: result_o = rn_i ^ op2_i.value;
      ade_pkg::OP_ORR:                  result_o = rn_i | op2_i.value;
      ade_pkg::OP_MOV:                  result_o = op2_i.value;
      ade_pkg::OP_BIC:                  result_o = rn_i & ~op2_i.value;
      ade_pkg::OP_MVN:                  result_o = ~op2_i.value;
      default:                          result_o = sum[31:0];
    endcase
  end

  assign write_enable_o = !((opcode_i == ade_pkg::OP_TST) || (opcode_i == ade_pkg::OP_TEQ) ||
                            (opcode_i == ade_pkg::OP_CMP) || (opcode_i == ade_pkg::OP_CMN));
  assign c_new = logical ? op2_i.carry : sum[32];
  assign v_new = logical ? flags_i.v : add_v;

  // s with rd = pc on a writing op restores the saved status instead
  assign restore_o = set_flags_i && write_enable_o && (rd_i == ade_pkg::PcIndex);

  always_comb begin
    if (set_flags_i && !restore_o) begin
      flags_o.n = result_o[31];
      flags_o.z = (result_o == 32'd0);
      flags_o.c = c_new;
      flags_o.v = v_new;
    end else begin
      flags_o = flags_i;
    end
  end

endmodule

// ===== rtl/arm_data_processing_execute.sv =====
// ----------------------------------------------------------------------------
// arm_data_processing_execute
// Data-processing execute stage: barrel shifter and ALU between an input
// register and a result register.
// ----------------------------------------------------------------------------
//  channel  direction  handshake               payload
//  in       input      in_valid_i / in_stall_o  opcode, instruction, rn/rm/rs, flags
//  out      output     out_valid_o / out_stall_i result, dest, write enable, flags, restore
//
//  one beat per cycle sustained while out_stall_i stays low; a taken beat
//  passes through the input register, then the result register
//  the shifter plus 32-bit adder between the two registers sets the cycle
//  rst_ni clears both valid flags, payload registers are not reset
//  a stalled result holds in the result register; the input register takes
//  one more beat before in_stall_o rises
// ----------------------------------------------------------------------------
module arm_data_processing_execute (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [3:0]  opcode_i,
  input  logic [31:0] instruction_i,
  input  logic [31:0] first_value_i,
  input  logic [31:0] second_value_i,
  input  logic [31:0] shift_value_i,
  input  logic [3:0]  flags_in_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] result_value_o,
  output logic [3:0]  dest_index_o,
  output logic        write_enable_o,
  output logic [3:0]  flags_out_o,
  output logic        restore_status_o
);

  logic        s1_valid_q;
  logic [3:0]  op_q;
  logic [31:0] ins_q;
  logic [31:0] rn_q;
  logic [31:0] rm_q;
  logic [31:0] rs_q;
  logic [3:0]  fl_q;

  logic        s2_ready;
  logic        s1_load;
  logic        pc_adj;
  logic [31:0] rn_adj;
  logic [31:0] rm_adj;

  ade_pkg::shift_out_t op2;
  ade_pkg::flags_t     alu_flags;
  logic [31:0]         alu_result;
  logic                alu_we;
  logic                alu_restore;

  assign s2_ready   = !out_valid_o || !out_stall_i;
  assign in_stall_o = s1_valid_q && !s2_ready;
  assign s1_load    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_load) begin
      op_q  <= opcode_i;
      ins_q <= instruction_i;
      rn_q  <= first_value_i;
      rm_q  <= second_value_i;
      rs_q  <= shift_value_i;
      fl_q  <= flags_in_i;
    end
  end

  // pc reads as +4 in register-shift form, rs never adjusted
  assign pc_adj = !ins_q[ade_pkg::InsImmBit] && ins_q[ade_pkg::InsRegShBit];
  assign rn_adj = (pc_adj && (ins_q[19:16] == ade_pkg::PcIndex)) ?
                  rn_q + ade_pkg::PcReadOffset : rn_q;
  assign rm_adj = (pc_adj && (ins_q[3:0] == ade_pkg::PcIndex)) ?
                  rm_q + ade_pkg::PcReadOffset : rm_q;

  ade_shifter u_shifter (
    .instruction_i (ins_q),
    .rm_i          (rm_adj),
    .rs_i          (rs_q),
    .carry_i       (fl_q[1]),
    .op2_o         (op2)
  );

  ade_alu u_alu (
    .opcode_i       (op_q),
    .set_flags_i    (ins_q[ade_pkg::InsSBit]),
    .rd_i           (ins_q[15:12]),
    .rn_i           (rn_adj),
    .op2_i          (op2),
    .flags_i        (ade_pkg::flags_t'(fl_q)),
    .result_o       (alu_result),
    .write_enable_o (alu_we),
    .flags_o        (alu_flags),
    .restore_o      (alu_restore)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (s2_ready) begin
      out_valid_o <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_ready && s1_valid_q) begin
      result_value_o   <= alu_result;
      dest_index_o     <= ins_q[15:12];
      write_enable_o   <= alu_we;
      flags_out_o      <= alu_flags;
      restore_status_o <= alu_restore;
    end
  end

`ifndef SYNTHESIS
  a_stall_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s1_valid_q && out_valid_o))
    else $error("input stalled with an empty input register");

  a_item_moves_on: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && s2_ready) |=> out_valid_o)
    else $error("item in input register did not reach the result register");

  a_rose_from_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(s1_valid_q))
    else $error("result appeared without an item");

  a_restore_pc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && restore_status_o) |->
      (write_enable_o && (dest_index_o == ade_pkg::PcIndex)))
    else $error("status restore without a pc write");
`endif

endmodule

// ===== dv/dp_execute_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dp_execute_checker
// Watches both channels of the data-processing execute block. For each
// accepted instruction beat it predicts the result beat: shifter operand,
// ALU value, NZCV update and status restore. It then compares every
// accepted result beat, in order, field by field.
// ----------------------------------------------------------------------------
module dp_execute_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_o,
  input  logic [3:0]  opcode_i,
  input  logic [31:0] instruction_i,
  input  logic [31:0] first_value_i,
  input  logic [31:0] second_value_i,
  input  logic [31:0] shift_value_i,
  input  logic [3:0]  flags_in_i,
  input  logic        out_valid_o,
  input  logic        out_stall_i,
  input  logic [31:0] result_value_o,
  input  logic [3:0]  dest_index_o,
  input  logic        write_enable_o,
  input  logic [3:0]  flags_out_o,
  input  logic        restore_status_o,
  output int          fail_count_o,
  output int          pending_o
);

  typedef struct packed {
    logic [31:0]     value;
    logic [3:0]      dest;
    logic            wr;
    ade_pkg::flags_t flags;
    logic            restore;
  } dp_result_t;

  dp_result_t expected_q[$];
  int fails = 0;
  int due = 0;
  int results_seen = 0;

  assign fail_count_o = fails;
  assign pending_o    = due;

  function automatic ade_pkg::shift_out_t barrel_shift(logic [31:0] ins, logic [31:0] rm,
                                                       logic [31:0] rs, logic cin);
    ade_pkg::shift_out_t  so;
    ade_pkg::shift_type_e kind;
    logic [7:0]           amt;
    logic [63:0]          spun;
    kind     = ade_pkg::shift_type_e'(ins[6:5]);
    so.value = rm;
    so.carry = cin;
    if (ins[ade_pkg::InsImmBit]) begin
      // 8-bit immediate rotated right by twice the rotate field
      spun     = {24'd0, ins[7:0], 24'd0, ins[7:0]} >> {ins[11:8], 1'b0};
      so.value = spun[31:0];
      if (ins[11:8] != 4'd0) so.carry = so.value[31];
    end else if (!ins[ade_pkg::InsRegShBit] && kind == ade_pkg::SH_ROR &&
                 ins[11:7] == 5'd0) begin
      // rrx: old carry enters at the top
      {so.value, so.carry} = {cin, rm};
    end else begin
      if (ins[ade_pkg::InsRegShBit]) amt = rs[7:0];
      else if (ins[11:7] == 5'd0 && kind != ade_pkg::SH_LSL) amt = 8'd32;
      else amt = {3'd0, ins[11:7]};
      if (amt != 8'd0) begin
        case (kind)
          ade_pkg::SH_LSL: {so.carry, so.value} = {1'b0, rm} << amt;
          ade_pkg::SH_LSR: {so.value, so.carry} = {rm, 1'b0} >> amt;
          ade_pkg::SH_ASR: {so.value, so.carry} = $signed({rm, 1'b0}) >>> amt;
          default: begin
            spun     = {rm, rm} >> amt[4:0];
            so.value = spun[31:0];
            so.carry = so.value[31];
          end
        endcase
      end
    end
    return so;
  endfunction

  // {overflow, carry, sum}
  function automatic logic [33:0] add_carry(logic [31:0] a, logic [31:0] b, logic ci);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b} + {32'd0, ci};
    return {(a[31] ^ s[31]) & (b[31] ^ s[31]), s};
  endfunction

  function automatic dp_result_t predict_execute(ade_pkg::alu_op_e op, logic [31:0] ins,
                                                 logic [31:0] rn, logic [31:0] rm,
                                                 logic [31:0] rs, ade_pkg::flags_t fl);
    dp_result_t          res;
    ade_pkg::shift_out_t op2;
    logic [33:0]         sum;
    logic [31:0]         r;
    logic                logical;
    ade_pkg::flags_t     nf;
    // pc reads ahead in register-shift form
    if (!ins[ade_pkg::InsImmBit] && ins[ade_pkg::InsRegShBit]) begin
      if (ins[19:16] == ade_pkg::PcIndex) rn = rn + ade_pkg::PcReadOffset;
      if (ins[3:0] == ade_pkg::PcIndex) rm = rm + ade_pkg::PcReadOffset;
    end
    op2     = barrel_shift(ins, rm, rs, fl.c);
    logical = 1'b0;
    sum     = '0;
    r       = '0;
    case (op)
      ade_pkg::OP_AND, ade_pkg::OP_TST: begin r = rn & op2.value; logical = 1'b1; end
      ade_pkg::OP_EOR, ade_pkg::OP_TEQ: begin r = rn ^ op2.value; logical = 1'b1; end
      ade_pkg::OP_SUB, ade_pkg::OP_CMP: sum = add_carry(rn, ~op2.value, 1'b1);
      ade_pkg::OP_RSB:         sum = add_carry(op2.value, ~rn, 1'b1);
      ade_pkg::OP_ADD, ade_pkg::OP_CMN: sum = add_carry(rn, op2.value, 1'b0);
      ade_pkg::OP_ADC:         sum = add_carry(rn, op2.value, fl.c);
      ade_pkg::OP_SBC:         sum = add_carry(rn, ~op2.value, fl.c);
      ade_pkg::OP_RSC:         sum = add_carry(op2.value, ~rn, fl.c);
      ade_pkg::OP_ORR:         begin r = rn | op2.value; logical = 1'b1; end
      ade_pkg::OP_MOV:         begin r = op2.value; logical = 1'b1; end
      ade_pkg::OP_BIC:         begin r = rn & ~op2.value; logical = 1'b1; end
      default:                 begin r = ~op2.value; logical = 1'b1; end
    endcase
    if (logical) begin
      nf.c = op2.carry;
      nf.v = fl.v;
    end else begin
      r    = sum[31:0];
      nf.c = sum[32];
      nf.v = sum[33];
    end
    nf.n = r[31];
    nf.z = (r == 32'd0);

    res.value   = r;
    res.dest    = ins[15:12];
    res.wr      = !(op inside {ade_pkg::OP_TST, ade_pkg::OP_TEQ,
                               ade_pkg::OP_CMP, ade_pkg::OP_CMN});
    res.flags   = fl;
    res.restore = 1'b0;
    if (ins[ade_pkg::InsSBit]) begin
      if (res.wr && res.dest == ade_pkg::PcIndex) res.restore = 1'b1;
      else res.flags = nf;
    end
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch at result %0d: %s got %h want %h", results_seen, what, got, want);
    fails++;
  endtask

  always @(posedge clk_i) begin
    dp_result_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_q.size() == 0) begin
          report_mismatch("result beat with none due", result_value_o, '0);
        end else begin
          want = expected_q.pop_front();
          if (result_value_o !== want.value)
            report_mismatch("result_value", result_value_o, want.value);
          if (dest_index_o !== want.dest)
            report_mismatch("dest_index", 32'(dest_index_o), 32'(want.dest));
          if (write_enable_o !== want.wr)
            report_mismatch("write_enable", 32'(write_enable_o), 32'(want.wr));
          if (flags_out_o !== want.flags)
            report_mismatch("flags_out", 32'(flags_out_o), 32'(want.flags));
          if (restore_status_o !== want.restore)
            report_mismatch("restore_status", 32'(restore_status_o), 32'(want.restore));
        end
        results_seen++;
      end
      if (in_valid_i && !in_stall_o)
        expected_q.push_back(predict_execute(ade_pkg::alu_op_e'(opcode_i), instruction_i,
                                             first_value_i, second_value_i,
                                             shift_value_i,
                                             ade_pkg::flags_t'(flags_in_i)));
      due <= expected_q.size();
    end
  end

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Testbench for the data-processing execute block. It sends directed
// instruction beats for the shifter and ALU corners, then random beats over
// several idle and stall mixes, including a long receiver hold-off. The
// checker beside the block scores the results.
// ----------------------------------------------------------------------------
module tb;

  localparam int HOLD_CYCLES      = 80;
  localparam int QUIET_LIMIT      = 1000;
  localparam int DRAIN_CYCLES     = 8;
  localparam int RANDOM_PER_PHASE = 330;
  localparam int NUM_PHASES       = 4;
  localparam int SendIdlePct[NUM_PHASES]  = '{0, 45, 0, 30};
  localparam int RecvStallPct[NUM_PHASES] = '{0, 0, 45, 30};

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [3:0]  opcode_i = '0;
  logic [31:0] instruction_i = '0;
  logic [31:0] first_value_i = '0;
  logic [31:0] second_value_i = '0;
  logic [31:0] shift_value_i = '0;
  logic [3:0]  flags_in_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [31:0] result_value_o;
  logic [3:0]  dest_index_o;
  logic        write_enable_o;
  logic [3:0]  flags_out_o;
  logic        restore_status_o;

  int mismatches;
  int results_due;
  int send_idle_pct = 0;
  int stall_pct = 0;
  int hold_req = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int quiet_cycles = 0;

  arm_data_processing_execute uut (.*);

  dp_execute_checker exec_check (
    .*,
    .fail_count_o (mismatches),
    .pending_o    (results_due)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // receiver: random stall, or a long hold-off when one is requested
  always @(posedge clk_i) begin
    if (hold_seen != hold_req) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left   = hold_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("no handshake for %0d cycles", quiet_cycles);
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic logic [31:0] dp_ins(logic imm, logic s, logic [3:0] rn,
                                         logic [3:0] rd, logic [11:0] op2);
    return {4'hE, 2'b00, imm, 4'd0, s, rn, rd, op2};
  endfunction

  function automatic logic [31:0] pick_word();
    case ($urandom_range(7))
      0:       return 32'd0;
      1:       return 32'hffff_ffff;
      2:       return 32'h8000_0000;
      3:       return 32'h7fff_ffff;
      4:       return 32'd1;
      5:       return 32'hffff_fffc;
      default: return $urandom();
    endcase
  endfunction

  task automatic send_beat(ade_pkg::alu_op_e op, logic [31:0] ins, logic [31:0] rn,
                           logic [31:0] rm, logic [31:0] rs, logic [3:0] fl);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    opcode_i       <= op;
    instruction_i  <= ins;
    first_value_i  <= rn;
    second_value_i <= rm;
    shift_value_i  <= rs;
    flags_in_i     <= fl;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic send_random_beat();
    logic [31:0] ins;
    logic [31:0] rs;
    ins = $urandom();
    case ($urandom_range(9))
      0, 1: begin
        ins[ade_pkg::InsImmBit] = 1'b1;
        if ($urandom_range(3) == 0) ins[11:8] = 4'd0;
      end
      2, 3, 4, 5: begin
        ins[ade_pkg::InsImmBit]   = 1'b0;
        ins[ade_pkg::InsRegShBit] = 1'b1;
      end
      default: begin
        ins[ade_pkg::InsImmBit]   = 1'b0;
        ins[ade_pkg::InsRegShBit] = 1'b0;
        if ($urandom_range(3) == 0) ins[11:7] = 5'd0;
      end
    endcase
    if ($urandom_range(3) == 0) ins[19:16] = ade_pkg::PcIndex;
    if ($urandom_range(3) == 0) ins[3:0] = ade_pkg::PcIndex;
    if ($urandom_range(3) == 0) ins[15:12] = ade_pkg::PcIndex;
    rs = $urandom();
    case ($urandom_range(7))
      0:       rs[7:0] = 8'd0;
      1:       rs[7:0] = 8'd32;
      2:       rs[7:0] = 8'($urandom_range(1, 31));
      3:       rs[7:0] = 8'($urandom_range(33, 255));
      4:       rs[7:0] = {3'($urandom_range(1, 7)), 5'd0};
      default: ;
    endcase
    send_beat(ade_pkg::alu_op_e'(4'($urandom_range(15))), ins, pick_word(), pick_word(),
              rs, 4'($urandom_range(15)));
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // immediate operand: rotate of zero keeps C, nonzero rotate gives bit 31
    send_beat(ade_pkg::OP_AND, dp_ins(1'b1, 1'b1, 4'd1, 4'd1, {4'd0, 8'hff}),
              32'hffff_ffff, 0, 0, 4'b0010);
    send_beat(ade_pkg::OP_EOR, dp_ins(1'b1, 1'b1, 4'd2, 4'd2, {4'd1, 8'hff}),
              32'd0, 0, 0, 4'b0000);
    // immediate shifts by zero: lsl keeps, lsr/asr mean 32, ror is rrx
    send_beat(ade_pkg::OP_SUB,
              dp_ins(1'b0, 1'b1, 4'd3, 4'd3, {5'd0, ade_pkg::SH_LSL, 1'b0, 4'd4}),
              32'd0, 32'hffff_ffff, 0, 4'b0000);
    send_beat(ade_pkg::OP_RSB,
              dp_ins(1'b0, 1'b1, 4'd4, 4'd4, {5'd0, ade_pkg::SH_LSR, 1'b0, 4'd5}),
              32'd1, 32'h8000_0000, 0, 4'b0010);
    send_beat(ade_pkg::OP_ADD,
              dp_ins(1'b0, 1'b1, 4'd5, 4'd5, {5'd0, ade_pkg::SH_ASR, 1'b0, 4'd6}),
              32'h7fff_ffff, 32'h8000_0000, 0, 4'b0000);
    send_beat(ade_pkg::OP_ADC,
              dp_ins(1'b0, 1'b1, 4'd6, 4'd6, {5'd0, ade_pkg::SH_ROR, 1'b0, 4'd7}),
              32'd0, 32'd1, 0, 4'b0010);
    // register shifts at 32 and beyond
    send_beat(ade_pkg::OP_SBC,
              dp_ins(1'b0, 1'b1, 4'd7, 4'd7, {4'd8, 1'b0, ade_pkg::SH_LSL, 1'b1, 4'd9}),
              32'd5, 32'd1, 32'd32, 4'b0000);
    send_beat(ade_pkg::OP_RSC,
              dp_ins(1'b0, 1'b1, 4'd8, 4'd8, {4'd8, 1'b0, ade_pkg::SH_LSR, 1'b1, 4'd9}),
              32'd3, 32'h8000_0000, 32'd32, 4'b0010);
    send_beat(ade_pkg::OP_TST,
              dp_ins(1'b0, 1'b1, 4'd9, ade_pkg::PcIndex,
                     {4'd8, 1'b0, ade_pkg::SH_LSL, 1'b1, 4'd9}),
              32'hffff_ffff, 32'hffff_ffff, 32'd40, 4'b1011);
    send_beat(ade_pkg::OP_TEQ,
              dp_ins(1'b0, 1'b1, 4'd9, 4'd9, {4'd8, 1'b0, ade_pkg::SH_LSR, 1'b1, 4'd9}),
              32'h8000_0000, 32'hffff_ffff, 32'h0000_00ff, 4'b0111);
    send_beat(ade_pkg::OP_CMP,
              dp_ins(1'b0, 1'b1, 4'd10, 4'd10, {4'd8, 1'b0, ade_pkg::SH_ASR, 1'b1, 4'd9}),
              32'd0, 32'h8000_0001, 32'd32, 4'b0000);
    send_beat(ade_pkg::OP_CMN,
              dp_ins(1'b0, 1'b1, 4'd11, 4'd11, {4'd8, 1'b0, ade_pkg::SH_ASR, 1'b1, 4'd9}),
              32'd1, 32'h7fff_ffff, 32'd200, 4'b0000);
    send_beat(ade_pkg::OP_ORR,
              dp_ins(1'b0, 1'b1, 4'd12, 4'd12, {4'd8, 1'b0, ade_pkg::SH_ROR, 1'b1, 4'd9}),
              32'd0, 32'h8000_0001, 32'd64, 4'b0000);
    // register amount of zero: low byte clear, upper bits set; then ror by 4
    send_beat(ade_pkg::OP_MOV,
              dp_ins(1'b0, 1'b1, 4'd13, 4'd13, {4'd8, 1'b0, ade_pkg::SH_ROR, 1'b1, 4'd9}),
              32'd0, 32'h1234_5678, 32'h0000_0100, 4'b0010);
    send_beat(ade_pkg::OP_BIC,
              dp_ins(1'b0, 1'b1, 4'd14, 4'd14, {4'd8, 1'b0, ade_pkg::SH_ROR, 1'b1, 4'd9}),
              32'hffff_ffff, 32'h0000_000f, 32'd4, 4'b0000);
    // writing op with S to the pc asks for a status restore
    send_beat(ade_pkg::OP_MVN,
              dp_ins(1'b1, 1'b1, 4'd0, ade_pkg::PcIndex, {4'd4, 8'h81}),
              32'd0, 0, 0, 4'b1010);
    // pc as rn and rm in register-shift form
    send_beat(ade_pkg::OP_ADD,
              dp_ins(1'b0, 1'b0, ade_pkg::PcIndex, 4'd2,
                     {4'd8, 1'b0, ade_pkg::SH_LSL, 1'b1, ade_pkg::PcIndex}),
              32'hffff_fffc, 32'd8, 32'd1, 4'b0101);
    send_beat(ade_pkg::OP_MOV,
              dp_ins(1'b0, 1'b0, 4'd0, 4'd3, {5'd31, ade_pkg::SH_LSL, 1'b0, 4'd1}),
              32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 4'b1111);
    // overflow and carry out of the adder
    send_beat(ade_pkg::OP_ADD,
              dp_ins(1'b0, 1'b1, 4'd1, 4'd4, {5'd0, ade_pkg::SH_LSL, 1'b0, 4'd2}),
              32'h7fff_ffff, 32'd1, 0, 4'b0000);
    send_beat(ade_pkg::OP_SUB,
              dp_ins(1'b0, 1'b1, 4'd1, 4'd5, {5'd0, ade_pkg::SH_LSL, 1'b0, 4'd2}),
              32'h8000_0000, 32'd1, 0, 4'b0000);
    send_beat(ade_pkg::OP_CMP,
              dp_ins(1'b0, 1'b0, 4'd1, ade_pkg::PcIndex,
                     {5'd0, ade_pkg::SH_LSL, 1'b0, 4'd2}),
              32'd7, 32'd7, 0, 4'b0110);
    send_beat(ade_pkg::OP_ADD,
              dp_ins(1'b0, 1'b1, 4'd1, 4'd6, {5'd0, ade_pkg::SH_LSL, 1'b0, 4'd2}),
              32'hffff_ffff, 32'd1, 0, 4'b1001);

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      // sender rests until every result beat is back
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while (results_due != 0);
      send_idle_pct = SendIdlePct[ph];
      stall_pct     <= RecvStallPct[ph];
      // long receiver hold-off while beats keep coming, fills the block
      if (ph == 0) hold_req <= hold_req + 1;
      repeat (RANDOM_PER_PHASE) send_random_beat();
    end

    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (results_due != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/ade_pkg.sv
rtl/ade_shifter.sv
rtl/ade_alu.sv
rtl/arm_data_processing_execute.sv
dv/dp_execute_checker.sv
dv/tb.sv
